// ----- design/hce_pkg.sv -----
`default_nettype none

package hce_pkg;

  // Implemented memory sizes in words
  localparam int DATA_WORDS   = 16384;
  localparam int SCREEN_WORDS = 8192;
  localparam int DATA_AW      = $clog2(DATA_WORDS);
  localparam int SCREEN_AW    = $clog2(SCREEN_WORDS);

  // Sweep length after reset covers the larger of the two memories
  localparam int CLR_WORDS = (DATA_WORDS > SCREEN_WORDS) ? DATA_WORDS : SCREEN_WORDS;
  localparam int CLR_W     = $clog2(CLR_WORDS);

  // Memory map
  localparam logic [15:0] SCREEN_BASE = 16'(16 << 10);
  localparam logic [15:0] KBD_ADDR    = 16'(24 << 10);

  // Instruction bit positions
  localparam int BIT_C  = 15;
  localparam int BIT_AM = 12;
  localparam int BIT_ZX = 11;
  localparam int BIT_NX = 10;
  localparam int BIT_ZY = 9;
  localparam int BIT_NY = 8;
  localparam int BIT_F  = 7;
  localparam int BIT_NO = 6;
  localparam int BIT_DA = 5;
  localparam int BIT_DD = 4;
  localparam int BIT_DM = 3;
  localparam int BIT_JN = 2;
  localparam int BIT_JZ = 1;
  localparam int BIT_JP = 0;

  // Stream widths
  localparam int IN_W  = 32;
  localparam int RES_W = 50;
  localparam int OUT_W = 56;

  // Memory write request from the execute stage
  typedef struct packed {
    logic        dat_we;
    logic        scr_we;
    logic [15:0] addr;
    logic [15:0] data;
  } mem_wr_t;

  // One result item; next_pc sits in the lowest bits
  typedef struct packed {
    logic        jump_taken;
    logic        kbd_read;
    logic [15:0] write_data;
    logic [14:0] write_address;
    logic        mem_write;
    logic [15:0] next_pc;
  } result_t;

  // Address lies in the data region and inside the implemented words
  function automatic logic data_hit(input logic [15:0] addr);
    return (addr[15:14] == 2'b00) && ({1'b0, addr[13:0]} < 15'(DATA_WORDS));
  endfunction

  // Address lies in the screen region and inside the implemented words
  function automatic logic screen_hit(input logic [15:0] addr);
    return (addr[15:13] == 3'b010) && ({1'b0, addr[12:0]} < 14'(SCREEN_WORDS));
  endfunction

endpackage

`default_nettype wire

// ----- design/hce_mem.sv -----
`default_nettype none

module hce_mem (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [15:0]     raddr,
  input  wire hce_pkg::mem_wr_t wr,
  output logic                 clearing,
  output logic [15:0]          dat_word,
  output logic [15:0]          scr_word
);
  import hce_pkg::*;

  logic [15:0] dmem [DATA_WORDS];
  logic [15:0] smem [SCREEN_WORDS];

  logic [CLR_W-1:0]     clr_idx;
  logic [DATA_AW-1:0]   d_widx;
  logic [SCREEN_AW-1:0] s_widx;
  logic [15:0]          wdata;
  logic                 d_we;
  logic                 s_we;
  logic [15:0]          d_rd;
  logic [15:0]          s_rd;
  logic                 d_fwd;
  logic                 s_fwd;
  logic [15:0]          fwd_data;

  // Clear sweep after reset, one word of each memory per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == CLR_W'(CLR_WORDS - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Write port: sweep while clearing, execute requests otherwise
  always_comb begin
    if (clearing) begin
      d_we   = {1'b0, clr_idx} < (CLR_W + 1)'(DATA_WORDS);
      s_we   = {1'b0, clr_idx} < (CLR_W + 1)'(SCREEN_WORDS);
      d_widx = clr_idx[DATA_AW-1:0];
      s_widx = clr_idx[SCREEN_AW-1:0];
      wdata  = '0;
    end else begin
      d_we   = wr.dat_we;
      s_we   = wr.scr_we;
      d_widx = wr.addr[DATA_AW-1:0];
      s_widx = wr.addr[SCREEN_AW-1:0];
      wdata  = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_widx] <= wdata;
    end
    if (s_we) begin
      smem[s_widx] <= wdata;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    d_rd <= dmem[raddr[DATA_AW-1:0]];
    s_rd <= smem[raddr[SCREEN_AW-1:0]];
  end

  // Bypass a write that hits the word being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      d_fwd <= 1'b0;
      s_fwd <= 1'b0;
    end else begin
      d_fwd <= !clearing && wr.dat_we && (wr.addr[DATA_AW-1:0] == raddr[DATA_AW-1:0]);
      s_fwd <= !clearing && wr.scr_we && (wr.addr[SCREEN_AW-1:0] == raddr[SCREEN_AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr.data;
  end

  assign dat_word = d_fwd ? fwd_data : d_rd;
  assign scr_word = s_fwd ? fwd_data : s_rd;

endmodule

`default_nettype wire

// ----- design/hce_exec.sv -----
`default_nettype none

module hce_exec (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [15:0]     instruction,
  input  wire logic [15:0]     keyboard_value,
  input  wire logic [15:0]     dat_word,
  input  wire logic [15:0]     scr_word,
  output logic [15:0]          raddr,
  output hce_pkg::mem_wr_t     wr,
  output hce_pkg::result_t     res
);
  import hce_pkg::*;

  logic [15:0] a_reg;
  logic [15:0] d_reg;
  logic [15:0] pc;
  logic [15:0] a_next;
  logic [15:0] d_next;
  logic [15:0] pc_next;

  logic        is_c;
  logic [15:0] m_val;
  logic        kbd_hit;
  logic [15:0] x_op;
  logic [15:0] y_op;
  logic [15:0] alu;
  logic        jump;
  logic        wrote;

  assign is_c = instruction[BIT_C];

  // M operand, selected by the region of the current A
  always_comb begin
    kbd_hit = 1'b0;
    if (a_reg[15:14] == 2'b00) begin
      m_val = data_hit(a_reg) ? dat_word : '0;
    end else if (a_reg[15:13] == 3'b010) begin
      m_val = screen_hit(a_reg) ? scr_word : '0;
    end else if (a_reg == KBD_ADDR) begin
      m_val   = keyboard_value;
      kbd_hit = 1'b1;
    end else begin
      m_val = a_reg;
    end
  end

  // ALU
  always_comb begin
    x_op = d_reg;
    if (instruction[BIT_ZX]) x_op = '0;
    if (instruction[BIT_NX]) x_op = ~x_op;
    y_op = instruction[BIT_AM] ? m_val : a_reg;
    if (instruction[BIT_ZY]) y_op = '0;
    if (instruction[BIT_NY]) y_op = ~y_op;
    alu = instruction[BIT_F] ? (x_op + y_op) : (x_op & y_op);
    if (instruction[BIT_NO]) alu = ~alu;
  end

  // Jump test against the sign and zero of the result
  assign jump = is_c &&
                ((instruction[BIT_JP] && !alu[15] && (alu != '0)) ||
                 (instruction[BIT_JZ] && (alu == '0)) ||
                 (instruction[BIT_JN] && alu[15]));

  // Memory write request
  assign wrote     = is_c && instruction[BIT_DM] && (data_hit(a_reg) || screen_hit(a_reg));
  assign wr.dat_we = accept && is_c && instruction[BIT_DM] && data_hit(a_reg);
  assign wr.scr_we = accept && is_c && instruction[BIT_DM] && screen_hit(a_reg);
  assign wr.addr   = a_reg;
  assign wr.data   = alu;

  // Register updates
  always_comb begin
    a_next  = a_reg;
    d_next  = d_reg;
    pc_next = pc;
    if (accept) begin
      pc_next = jump ? a_reg : pc + 16'd1;
      if (!is_c) begin
        a_next = instruction;
      end else begin
        if (instruction[BIT_DA]) a_next = alu;
        if (instruction[BIT_DD]) d_next = alu;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_reg <= '0;
      d_reg <= '0;
      pc    <= '0;
    end else begin
      a_reg <= a_next;
      d_reg <= d_next;
      pc    <= pc_next;
    end
  end

  // Next read follows the A value of the coming cycle
  assign raddr = a_next;

  // Result item
  always_comb begin
    res.next_pc       = pc_next;
    res.mem_write     = wrote;
    res.write_address = wrote ? a_reg[14:0] : '0;
    res.write_data    = wrote ? alu : '0;
    res.kbd_read      = is_c && instruction[BIT_AM] && kbd_hit;
    res.jump_taken    = jump;
  end

endmodule

`default_nettype wire

// ----- design/hce_obuf.sv -----
`default_nettype none

module hce_obuf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire hce_pkg::result_t in_data,
  output logic                 in_ready,
  output logic                 out_valid,
  output hce_pkg::result_t     out_data,
  input  wire logic            out_ready
);
  import hce_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign in_ready = !skid_valid;
  assign take     = in_valid && in_ready;

  // Output register with a one-entry skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (take && out_valid && !out_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/hack_cpu_execute_unit.sv -----
// Hack CPU execute unit.
// Input stream s_axis: one request per instruction, fetched by the host at
// the current program counter, together with the current keyboard code.
// Output stream m_axis: one result per request, in order: the next pc, the
// memory write (for mirroring the screen) and keyboard/jump flags.
// Throughput is one instruction per cycle while s_axis_tready is high; each result
// is registered in the output register, or in the skid stage while m_axis_tready
// is low. A, D and PC are registers; data and screen memory are synchronous RAMs
// read ahead at the next A, with a bypass when a store hits the word being read.
// After reset A, D and PC are zero and both memories are swept to zero,
// one word per cycle: s_axis_tready stays low until the sweep has covered
// the larger memory (16384 words at the default sizes).
// An output register and a one-entry skid stage sit in front of m_axis;
// while m_axis_tready is low one more request is taken, then
// s_axis_tready drops until the receiver takes a result and frees the skid stage.
`default_nettype none

module hack_cpu_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] instruction, [31:16] keyboard_value
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] next_pc, [16] mem_write, [31:17] write_address, [47:32] write_data,
  // [48] kbd_read, [49] jump_taken, [55:50] zero
  output logic [55:0]      m_axis_tdata
);
  import hce_pkg::*;

  logic        clearing;
  logic        buf_ready;
  logic        accept;
  logic [15:0] raddr;
  logic [15:0] dat_word;
  logic [15:0] scr_word;
  mem_wr_t     wr;
  result_t     res;
  result_t     out_res;

  assign s_axis_tready = !clearing && buf_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  hce_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .raddr    (raddr),
    .wr       (wr),
    .clearing (clearing),
    .dat_word (dat_word),
    .scr_word (scr_word)
  );

  hce_exec u_exec (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .instruction    (s_axis_tdata[15:0]),
    .keyboard_value (s_axis_tdata[31:16]),
    .dat_word       (dat_word),
    .scr_word       (scr_word),
    .raddr          (raddr),
    .wr             (wr),
    .res            (res)
  );

  hce_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_data   (res),
    .in_ready  (buf_ready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {(OUT_W - RES_W)'(0), out_res};

`ifndef SYNTH
  // No request is taken during the clear sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready) else $error("request accepted during clear");

  // After an accepted request m_axis_tvalid is always high in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid) else $error("result missing after accept");

  // Stores only come from accepted requests
  a_store_on_accept: assert property (@(posedge clk) disable iff (rst)
    (wr.dat_we || wr.scr_we) |-> accept) else $error("store without request");

  // A store goes to one memory at most
  a_one_memory: assert property (@(posedge clk) disable iff (rst)
    !(wr.dat_we && wr.scr_we)) else $error("store to both memories");
`endif

endmodule

`default_nettype wire
